FILE: sv/pcxrle_pkg.sv
// shared types and constants for the pcx run-length line encoder
`default_nettype none

package pcxrle_pkg;

   localparam int unsigned PIXEL_W = 8;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned WIDTH_W = 16;

   localparam logic [PIXEL_W-1:0] COUNT_MARK    = 8'hC0;
   localparam logic [WIDTH_W-1:0] WIDTH_DEFAULT = 16'd320;

   // one run to be written out, count of zero means nothing to write
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
      logic [PIXEL_W-1:0] value;
   } run_type;

   // everything one pixel causes: the run it closes, then the run flushed at line end
   typedef struct packed {
      run_type first;
      run_type second;
   } job_type;

endpackage

`default_nettype wire

FILE: sv/pcxrle_front.sv
// front end: run tracking, column counting and line width register
`default_nettype none

module pcxrle_front
   import pcxrle_pkg::*;
#(
   parameter int unsigned MAX_RUN = 63
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pixel_valid,
   input  wire logic [PIXEL_W-1:0] pixel,
   input  wire logic               width_write,
   input  wire logic [WIDTH_W-1:0] width_value,
   output job_type                 job,
   output logic                    job_valid
);

   logic [PIXEL_W-1:0] held_ff, held_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WIDTH_W-1:0] column_ff, column_in;
   logic [WIDTH_W-1:0] width_ff;

   logic [PIXEL_W-1:0] held_mid;
   logic [COUNT_W-1:0] count_mid;
   logic [COUNT_W-1:0] count_inc;
   logic [WIDTH_W:0]   column_next;
   logic               line_end;

   always_comb begin
      held_mid  = held_ff;
      count_mid = count_ff;
      count_inc = count_ff + COUNT_W'(1);
      job.first = '{valid: 1'b0, count: count_ff, value: held_ff};

      if (column_ff == '0) begin
         held_mid  = pixel;
         count_mid = COUNT_W'(1);
      end else if (pixel == held_ff) begin
         count_mid = count_inc;
         if (count_inc == COUNT_W'(MAX_RUN)) begin
            job.first = '{valid: 1'b1, count: count_inc, value: held_ff};
            count_mid = '0;
         end
      end else begin
         job.first = '{valid: (count_ff != '0), count: count_ff, value: held_ff};
         held_mid  = pixel;
         count_mid = COUNT_W'(1);
      end

      // zero width behaves as one pixel per line
      column_next = {1'b0, column_ff} + (WIDTH_W+1)'(1);
      line_end    = (column_next >= {1'b0, width_ff});

      job.second = '{valid: line_end && (count_mid != '0), count: count_mid, value: held_mid};
      held_in    = held_mid;
      if (line_end) begin
         count_in  = '0;
         column_in = '0;
      end else begin
         count_in  = count_mid;
         column_in = column_next[WIDTH_W-1:0];
      end

      job_valid = pixel_valid && (job.first.valid || job.second.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= '0;
         count_ff  <= '0;
         column_ff <= '0;
         width_ff  <= WIDTH_DEFAULT;
      end else begin
         if (pixel_valid) begin
            held_ff   <= held_in;
            count_ff  <= count_in;
            column_ff <= column_in;
         end
         if (width_write) begin
            width_ff <= width_value;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/pcxrle_queue.sv
// small register queue of jobs between front and back
`default_nettype none

module pcxrle_queue
   import pcxrle_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  job_type      push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head_job,
   output logic         head_valid
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: sv/pcxrle_back.sv
// back end: expands one job into encoded bytes, one byte per cycle while the output register is empty or taken
`default_nettype none

module pcxrle_back
   import pcxrle_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  job_type                 head_job,
   input  wire logic               head_valid,
   output logic                    head_pop,
   output logic                    out_valid,
   input  wire logic               out_take,
   output logic [PIXEL_W-1:0]      out_byte,
   output logic                    out_last
);

   logic [1:0]         step_ff, step_in;
   logic               valid_ff, valid_in;
   logic [PIXEL_W-1:0] byte_ff, byte_in;
   logic               last_ff, last_in;

   logic               bare_a, bare_b;
   logic [2:0]         len_a, len_b, len_total;
   logic [2:0]         step_ext, step_b;
   logic [PIXEL_W-1:0] pick;
   logic               load, at_end;

   // single run with top bits not both set goes out as the bare value
   function automatic logic is_bare(run_type r);
      is_bare = (r.count == COUNT_W'(1)) && (r.value[7:6] != 2'b11);
   endfunction

   function automatic logic [PIXEL_W-1:0] count_byte(run_type r);
      count_byte = COUNT_MARK | {{(PIXEL_W-COUNT_W){1'b0}}, r.count};
   endfunction

   always_comb begin
      bare_a    = is_bare(head_job.first);
      bare_b    = is_bare(head_job.second);
      len_a     = head_job.first.valid  ? (bare_a ? 3'd1 : 3'd2) : 3'd0;
      len_b     = head_job.second.valid ? (bare_b ? 3'd1 : 3'd2) : 3'd0;
      len_total = len_a + len_b;
      step_ext  = {1'b0, step_ff};
      step_b    = step_ext - len_a;

      if (step_ext < len_a) begin
         pick = (step_ff == 2'd0 && !bare_a) ? count_byte(head_job.first)
                                             : head_job.first.value;
      end else begin
         pick = (step_b == 3'd0 && !bare_b) ? count_byte(head_job.second)
                                            : head_job.second.value;
      end

      at_end   = (step_ext == len_total - 3'd1);
      load     = head_valid && (!valid_ff || out_take);
      head_pop = load && at_end;

      step_in  = step_ff;
      valid_in = valid_ff && !out_take;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = pick;
         last_in  = at_end;
         step_in  = at_end ? 2'd0 : step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

FILE: sv/pcx_rle_line_encoder_core.sv
// top level of the pcx run-length line encoder
`default_nettype none

// pcx-style run-length encoder for 8-bit palette-index scanlines. pixels
// enter through a queue-like port (push/full) and encoded bytes leave through
// another (empty/pop); rsp_last marks the final byte a pixel produced, and a
// pixel that closes no run produces nothing. a front stage tracks the open
// run and the column and accepts one pixel per cycle while the job queue has
// room; a back stage writes one encoded byte per cycle into the output
// register while that register is empty or being popped. a pixel yields
// up to four bytes, at a line end where a closed run and the flushed run
// meet. its first byte passes through the job queue and then the output
// register before it can be popped. line width is written over the csr port,
// which is always ready; the user must write it only while the encoder is
// idle, the block itself does not enforce this; a width of zero acts as one.
module pcx_rle_line_encoder_core
   import pcxrle_pkg::*;
#(
   parameter int unsigned MAX_RUN     = 63,  // longest run, 2 to 63
   parameter int unsigned QUEUE_DEPTH = 4    // jobs buffered between front and back
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // pixel input
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   // encoded byte output
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [PIXEL_W-1:0]      rsp_out_byte,
   output logic                    rsp_last,
   // line width register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [WIDTH_W-1:0] csr_line_width
);

   job_type front_job;
   job_type head_job;
   logic    front_job_valid;
   logic    queue_full;
   logic    head_valid;
   logic    head_pop;
   logic    accept;
   logic    out_valid;

   // pixel transaction lands when the job queue can take whatever it causes
   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;
   assign csr_ready = 1'b1;

   pcxrle_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .pixel_valid (accept),
      .pixel       (req_pixel),
      .width_write (csr_valid),
      .width_value (csr_line_width),
      .job         (front_job),
      .job_valid   (front_job_valid)
   );

   // pixels that only extend a run never enter the queue
   pcxrle_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_job_valid),
      .push_job   (front_job),
      .full       (queue_full),
      .pop        (head_pop),
      .head_job   (head_job),
      .head_valid (head_valid)
   );

   // output register refills in the cycle it is popped when a job waits, so one byte per cycle
   pcxrle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .out_valid  (out_valid),
      .out_take   (rsp_pop),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last)
   );

   assign rsp_empty = !out_valid;

endmodule

`default_nettype wire

FILE: dv/pcx_rle_stream_checker.sv
// checker for the pcx run-length line encoder: predicts encoded bytes and compares
`default_nettype none

module pcx_rle_stream_checker
   import pcxrle_pkg::*;
#(
   parameter int unsigned MAX_RUN = 63
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic               req_full,
   input  wire logic [PIXEL_W-1:0] req_pixel,
   input  wire logic               rsp_empty,
   input  wire logic               rsp_pop,
   input  wire logic [PIXEL_W-1:0] rsp_out_byte,
   input  wire logic               rsp_last,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [WIDTH_W-1:0] csr_line_width,
   output int                      pending,
   output int                      failures
);

   // encoded bytes still owed by the encoder, oldest first
   logic [PIXEL_W-1:0] coded_bytes[$];
   logic               coded_last[$];

   // shadow of the encoder state
   logic [WIDTH_W-1:0] width_shadow;
   logic [PIXEL_W-1:0] run_value;
   logic [COUNT_W-1:0] run_len;
   logic [WIDTH_W-1:0] col;

   int fail_count = 0;

   assign failures = fail_count;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // write out the open run, if any
   task automatic close_run();
      if (run_len == '0) begin
      end else if (run_len == COUNT_W'(1) && run_value[7:6] != 2'b11) begin
         coded_bytes.push_back(run_value);
         coded_last.push_back(1'b0);
      end else begin
         coded_bytes.push_back(COUNT_MARK | PIXEL_W'(run_len));
         coded_last.push_back(1'b0);
         coded_bytes.push_back(run_value);
         coded_last.push_back(1'b0);
      end
   endtask

   task automatic encode_pixel(input logic [PIXEL_W-1:0] px);
      int prior;
      prior = coded_bytes.size();
      if (col == '0) begin
         run_value = px;
         run_len   = COUNT_W'(1);
      end else if (px == run_value) begin
         run_len = run_len + COUNT_W'(1);
         if (int'(run_len) == MAX_RUN) begin
            close_run();
            run_len = '0;
         end
      end else begin
         close_run();
         run_value = px;
         run_len   = COUNT_W'(1);
      end
      // line end, a zero width behaves as one
      if (int'(col) + 1 >= int'(width_shadow)) begin
         close_run();
         run_len = '0;
         col     = '0;
      end else begin
         col = col + WIDTH_W'(1);
      end
      if (coded_bytes.size() > prior)
         coded_last[coded_last.size()-1] = 1'b1;
   endtask

   always @(posedge clock) begin
      logic [PIXEL_W-1:0] want_byte;
      logic               want_last;
      if (reset) begin
         coded_bytes.delete();
         coded_last.delete();
         width_shadow = WIDTH_DEFAULT;
         run_value    = '0;
         run_len      = '0;
         col          = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (coded_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_out_byte, rsp_last));
            end else begin
               want_byte = coded_bytes.pop_front();
               want_last = coded_last.pop_front();
               if (rsp_out_byte !== want_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, want_byte));
               if (rsp_last !== want_last)
                  report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                            rsp_last, want_byte, want_last));
            end
         end
         if (csr_valid && csr_ready)
            width_shadow = csr_line_width;
         if (req_push && !req_full)
            encode_pixel(req_pixel);
      end
      pending = coded_bytes.size();
   end

endmodule

`default_nettype wire

FILE: dv/tb_pcx_rle_line_encoder_core.sv
// testbench top for the pcx run-length line encoder: stimulus, idling and verdict
`default_nettype none

module tb_pcx_rle_line_encoder_core;
   import pcxrle_pkg::*;

   localparam int PIXEL_TARGET = 310;   // random pixels to send
   localparam int CALM_TAIL    = 40;    // last pixels sent with no idling on either side
   localparam int DRAIN_CYCLES = 12;    // margin after the last owed byte has been popped

   logic               clock = 1'b0;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [PIXEL_W-1:0] req_pixel;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [PIXEL_W-1:0] rsp_out_byte;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [WIDTH_W-1:0] csr_line_width;

   int pending;
   int failures;

   // set for the tail of the run: no gaps from the sender, no stalls from the receiver
   logic calm = 1'b0;

   // stall counter for the receiver side
   int unsigned pop_hold = 0;

   always #2 clock = ~clock;

   pcx_rle_line_encoder_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel      (req_pixel),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width)
   );

   pcx_rle_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel      (req_pixel),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width),
      .pending        (pending),
      .failures       (failures)
   );

   // receiver: pop held low in random bursts while not calm, otherwise high
   always @(negedge clock) begin
      if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop  <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         pop_hold <= $urandom_range(0, 12);
         rsp_pop  <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // one pixel transaction; entered and left at a falling edge, push stays high
   // afterwards so back-to-back pixels need no second assignment in one step
   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_push  <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // stop sending, wait for every owed byte, then let the job queue drain
   task automatic settle();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // line width write, only while the encoder is idle
   task automatic write_width(input logic [WIDTH_W-1:0] w);
      settle();
      csr_valid      <= 1'b1;
      csr_line_width <= w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random pixel value, biased toward the edges of the four top-bit ranges, one of which holds the count bytes
   function automatic logic [PIXEL_W-1:0] pick_value();
      logic [PIXEL_W-1:0] corner;
      case ($urandom_range(0, 7))
         0: corner = 8'h00;
         1: corner = 8'h3F;
         2: corner = 8'h40;
         3: corner = 8'h7F;
         4: corner = 8'h80;
         5: corner = 8'hBF;
         6: corner = COUNT_MARK;
         default: corner = 8'hFF;
      endcase
      if ($urandom_range(0, 1) == 0)
         return corner;
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [WIDTH_W-1:0] pick_width();
      case ($urandom_range(0, 7))
         0: return '0;                                  // acts as one
         1: return WIDTH_W'(1);
         2: return WIDTH_W'(2);
         3: return '1;                                  // widest line
         4: return WIDTH_W'($urandom_range(3, 16));
         5: return WIDTH_W'($urandom_range(60, 140));   // room for runs past the cut
         default: return WIDTH_W'($urandom_range(3, 40));
      endcase
   endfunction

   initial begin
      int                 sent;
      int                 phase_len;
      int                 run_left;
      logic [PIXEL_W-1:0] run_px;

      reset          = 1'b1;
      req_push       = 1'b0;
      req_pixel      = '0;
      csr_valid      = 1'b0;
      csr_line_width = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset width of 320: bare bytes, lone bytes that need a count, short runs
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(COUNT_MARK);
      send_pixel(8'h3F);
      send_pixel(8'h3F);
      send_pixel(8'h40);
      send_pixel(8'h40);
      send_pixel(8'h40);

      // zero width: every pixel is a line of its own
      write_width('0);
      send_pixel(8'hC1);
      send_pixel(8'h01);
      send_pixel(8'h01);

      // widest line, then the width lowered below the current column mid-line
      write_width('1);
      send_pixel(8'h80);
      send_pixel(8'h80);
      send_pixel(8'h7F);
      write_width(WIDTH_W'(2));
      send_pixel(8'h7F);

      // width of one, then a short line where a run is flushed at line end
      write_width(WIDTH_W'(1));
      send_pixel(8'hAA);
      send_pixel(8'h55);
      write_width(WIDTH_W'(4));
      repeat (5) send_pixel(8'h12);

      // random phases: a width per phase, pixels as runs of random length;
      // long runs cross the cut at the longest run
      sent = 0;
      while (sent < PIXEL_TARGET) begin
         write_width(pick_width());
         phase_len = $urandom_range(20, 45);
         run_left  = 0;
         run_px    = '0;
         while (phase_len > 0 && sent < PIXEL_TARGET) begin
            if (run_left == 0) begin
               run_px   = pick_value();
               run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130)
                                                      : $urandom_range(1, 4);
            end
            if (sent >= PIXEL_TARGET - CALM_TAIL)
               calm <= 1'b1;
            send_pixel(run_px);
            run_left--;
            phase_len--;
            sent++;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
